>>> sv/imutc_pkg.sv
// ----------------------------------------------------------------------------
// imutc_pkg
// Shared widths, register indexes, CORDIC angle table and clamp helper for
// the IMU tilt and rate conditioner.
// ----------------------------------------------------------------------------
package imutc_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES = 2'd2;

  // serial divider
  localparam int DIV_W     = 37;
  localparam int DVS_W     = 16;
  localparam int DIV_LEN_W = 6;
  localparam logic [DIV_LEN_W-1:0] DIV_LEN_BIAS = 6'd37;
  localparam logic [DIV_LEN_W-1:0] DIV_LEN_RES  = 6'd28;

  // square root
  localparam int SQ_W   = 32;
  localparam int ROOT_W = 16;

  // CORDIC
  localparam int CORDIC_IN_W = 18;
  localparam int CORDIC_XY_W = 34;
  localparam int CORDIC_Z_W  = 33;
  localparam int ANG_W       = 18;
  localparam int ATAN_IDX_W  = 5;
  localparam int ATAN_W      = 29;
  localparam int PRESHIFT    = 14;
  localparam logic signed [CORDIC_Z_W-1:0] Z_HALF_TURN = 33'sd1179648000;
  localparam logic signed [CORDIC_Z_W-1:0] Z_ROUND     = 33'sd32768;

  // atan(2^-i) in centidegrees * 65536
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 29'd294912000;
      5'd1:  v = 29'd174096719;
      5'd2:  v = 29'd91987925;
      5'd3:  v = 29'd46694507;
      5'd4:  v = 29'd23437865;
      5'd5:  v = 29'd11730358;
      5'd6:  v = 29'd5866610;
      5'd7:  v = 29'd2933484;
      5'd8:  v = 29'd1466764;
      5'd9:  v = 29'd733385;
      5'd10: v = 29'd366693;
      5'd11: v = 29'd183346;
      5'd12: v = 29'd91673;
      5'd13: v = 29'd45837;
      5'd14: v = 29'd22918;
      5'd15: v = 29'd11459;
      5'd16: v = 29'd5730;
      5'd17: v = 29'd2865;
      5'd18: v = 29'd1432;
      5'd19: v = 29'd716;
      5'd20: v = 29'd358;
      5'd21: v = 29'd179;
      5'd22: v = 29'd90;
      5'd23: v = 29'd45;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DIV_W-1:0] clamp_s(input logic signed [DIV_W-1:0] v,
                                                      input logic signed [DIV_W-1:0] lim);
    logic signed [DIV_W-1:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

>>> sv/imu_tilt_and_rate_conditioner_top.sv
// A calibration request adds its gyro sample to the bias sums; the last one then runs
// three bias divisions. A result request runs the square root, a CORDIC angle each for
// pitch and roll, and six quotients from the shared serial divider, then loads out.
// Throughput: one request at a time; in_tready is low while one is in work.
// Reset: synchronous rst_n restores register defaults, clears calibration and bias.
// ----------------------------------------------------------------------------
// imu_tilt_and_rate_conditioner_top
// Gyro bias calibration, unit scaling of accel and gyro, pitch and roll via
// CORDIC, sequenced over a shared divider, square root and CORDIC unit.
// ----------------------------------------------------------------------------
module imu_tilt_and_rate_conditioner_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imutc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
  input  logic [95:0]                        in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pitch_cdeg(15), roll_cdeg(16), accel_x/y/z_mg(15 each), rate_x/y/z_cdps(20 each)
  output logic [135:0]                       out_tdata
);
  import imutc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BIAS  = 7'b0000010,
    ST_SQRT  = 7'b0000100,
    ST_PITCH = 7'b0001000,
    ST_ROLL  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  localparam logic [2:0] OP_ACC_LAST  = 3'd2;
  localparam logic [2:0] OP_RATE_X    = 3'd3;
  localparam logic [2:0] OP_RATE_LAST = 3'd5;
  localparam logic [1:0] AXIS_LAST    = 2'd2;

  state_t                state_r;
  logic                  go_r;
  logic [2:0]            op_r;
  logic [14:0]           accel_scale_r;
  logic [7:0]            gyro_scale_r;
  logic [15:0]           cal_samples_r;
  logic [15:0]           cal_count_r;
  logic signed [32:0]    bias_sum_r [3];
  logic signed [20:0]    bias_q4_r [3];
  logic signed [15:0]    acc_r [3];
  logic signed [15:0]    gyr_r [3];
  logic signed [14:0]    pitch_r;
  logic signed [15:0]    roll_r;
  logic signed [14:0]    mg_r [3];
  logic signed [19:0]    rate_r [3];
  logic                  out_tvalid_r;
  logic [135:0]          out_tdata_r;

  logic                  in_acc;
  logic                  calib;
  logic                  cal_last;
  logic signed [15:0]    g_in [3];
  logic [1:0]            k_acc;
  logic [1:0]            k_rate;
  logic [2:0]            op_m3;
  logic [14:0]           as_eff;
  logic [7:0]            gs_eff;

  logic                  div_start, div_busy, div_done;
  logic signed [DIV_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0]      div_dvs;
  logic [DIV_LEN_W-1:0]  div_len;

  logic                  sq_start, sq_busy, sq_done;
  logic [SQ_W-1:0]       sq_val;
  logic [ROOT_W-1:0]     sq_root;

  logic                  cd_start, cd_busy, cd_done;
  logic signed [CORDIC_IN_W-1:0] cd_y, cd_x;
  logic signed [ANG_W-1:0] cd_ang;
  logic signed [31:0]    sq_y, sq_z;

  assign in_tready = (state_r == ST_IDLE);
  // hold register writes while a request is in work
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign calib     = cal_count_r < cal_samples_r;
  assign cal_last  = ({1'b0, cal_count_r} + 17'd1) == {1'b0, cal_samples_r};

  assign g_in[0] = $signed(in_tdata[63:48]);
  assign g_in[1] = $signed(in_tdata[79:64]);
  assign g_in[2] = $signed(in_tdata[95:80]);

  assign op_m3  = op_r - OP_RATE_X;
  assign k_acc  = op_r[1:0];
  assign k_rate = op_m3[1:0];
  assign as_eff = (accel_scale_r == '0) ? 15'd1 : accel_scale_r;
  assign gs_eff = (gyro_scale_r == '0) ? 8'd1 : gyro_scale_r;

  // divider operand select
  always_comb begin
    if (state_r == ST_BIAS) begin
      div_dvd = DIV_W'(bias_sum_r[k_acc]) <<< 4;
      div_dvs = cal_samples_r;
      div_len = DIV_LEN_BIAS;
    end else if (op_r <= OP_ACC_LAST) begin
      div_dvd = DIV_W'(acc_r[k_acc]) * 37'sd1000;
      div_dvs = DVS_W'(as_eff);
      div_len = DIV_LEN_RES;
    end else begin
      div_dvd = ((DIV_W'(gyr_r[k_rate]) <<< 4) - DIV_W'(bias_q4_r[k_rate])) * 37'sd100;
      div_dvs = DVS_W'({gs_eff, 4'b0000});
      div_len = DIV_LEN_RES;
    end
  end

  assign sq_y   = 32'(acc_r[1]) * 32'(acc_r[1]);
  assign sq_z   = 32'(acc_r[2]) * 32'(acc_r[2]);
  assign sq_val = SQ_W'(sq_y) + SQ_W'(sq_z);

  always_comb begin
    if (state_r == ST_PITCH) begin
      cd_y = -CORDIC_IN_W'(acc_r[0]);
      cd_x = $signed({{(CORDIC_IN_W-ROOT_W){1'b0}}, sq_root});
    end else begin
      cd_y = CORDIC_IN_W'(acc_r[1]);
      cd_x = CORDIC_IN_W'(acc_r[2]);
    end
  end

  assign div_start = go_r && (state_r == ST_BIAS || state_r == ST_DIV);
  assign sq_start  = go_r && (state_r == ST_SQRT);
  assign cd_start  = go_r && (state_r == ST_PITCH || state_r == ST_ROLL);

  imutc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .len(div_len), .busy(div_busy), .done(div_done),
    .quotient(div_quo)
  );

  imutc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(sq_val),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  imutc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cd_start), .y_in(cd_y), .x_in(cd_x),
    .busy(cd_busy), .done(cd_done), .angle(cd_ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      go_r          <= 1'b0;
      op_r          <= '0;
      accel_scale_r <= 15'd16384;
      gyro_scale_r  <= 8'd131;
      cal_samples_r <= 16'd1000;
      cal_count_r   <= '0;
      out_tvalid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        bias_sum_r[k] <= '0;
        bias_q4_r[k]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACCEL_SCALE: accel_scale_r <= cfg_data[14:0];
          REG_GYRO_SCALE:  gyro_scale_r  <= cfg_data[7:0];
          REG_CAL_SAMPLES: cal_samples_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && state_r != ST_OUT) out_tvalid_r <= 1'b0;
      if (div_start || sq_start || cd_start) go_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            acc_r[0] <= $signed(in_tdata[15:0]);
            acc_r[1] <= $signed(in_tdata[31:16]);
            acc_r[2] <= $signed(in_tdata[47:32]);
            for (int k = 0; k < 3; k++) gyr_r[k] <= g_in[k];
            if (calib) begin
              for (int k = 0; k < 3; k++) bias_sum_r[k] <= bias_sum_r[k] + 33'(g_in[k]);
              cal_count_r <= cal_count_r + 16'd1;
              if (cal_last) begin
                state_r <= ST_BIAS;
                op_r    <= '0;
                go_r    <= 1'b1;
              end
            end else begin
              state_r <= ST_SQRT;
              go_r    <= 1'b1;
            end
          end
        end
        ST_BIAS: begin
          if (div_done) begin
            bias_q4_r[k_acc] <= div_quo[20:0];
            if (k_acc == AXIS_LAST) begin
              state_r <= ST_IDLE;
            end else begin
              op_r <= op_r + 3'd1;
              go_r <= 1'b1;
            end
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            state_r <= ST_PITCH;
            go_r    <= 1'b1;
          end
        end
        ST_PITCH: begin
          if (cd_done) begin
            pitch_r <= 15'(clamp_s(DIV_W'(cd_ang), 37'sd9000));
            state_r <= ST_ROLL;
            go_r    <= 1'b1;
          end
        end
        ST_ROLL: begin
          if (cd_done) begin
            roll_r  <= 16'(clamp_s(DIV_W'(cd_ang), 37'sd18000));
            state_r <= ST_DIV;
            op_r    <= '0;
            go_r    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (op_r <= OP_ACC_LAST) mg_r[k_acc] <= 15'(clamp_s(div_quo, 37'sd16000));
            else rate_r[k_rate] <= 20'(clamp_s(div_quo, 37'sd409600));
            if (op_r == OP_RATE_LAST) begin
              state_r <= ST_OUT;
            end else begin
              op_r <= op_r + 3'd1;
              go_r <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {rate_r[2], rate_r[1], rate_r[0],
                             mg_r[2], mg_r[1], mg_r[0], roll_r, pitch_r};
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({div_busy, sq_busy, cd_busy}))
    else $error("more than one arithmetic unit busy");

  a_cal_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && calib) |=> (state_r == ST_IDLE || state_r == ST_BIAS))
    else $error("calibration request entered the result path");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output state");

endmodule

>>> sv/imutc_div.sv
// ----------------------------------------------------------------------------
// imutc_div
// Restoring serial divider, one quotient bit per cycle, signed dividend over
// unsigned divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module imutc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [imutc_pkg::DIV_W-1:0]   dividend,
  input  logic [imutc_pkg::DVS_W-1:0]          divisor,
  input  logic [imutc_pkg::DIV_LEN_W-1:0]      len,
  output logic                                 busy,
  output logic                                 done,
  output logic signed [imutc_pkg::DIV_W-1:0]   quotient
);
  import imutc_pkg::*;

  logic [DIV_W-1:0]     q_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     d_r;
  logic [DIV_LEN_W-1:0] cnt_r;
  logic                 neg_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_W-1:0]     mag;
  logic [DIV_LEN_W-1:0] sh;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign mag   = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
  assign sh    = DIV_LEN_W'(DIV_W) - len;
  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // left-align the dividend so only len steps are needed
        q_r    <= mag << sh;
        rem_r  <= '0;
        d_r    <= divisor;
        cnt_r  <= len;
        neg_r  <= dividend[DIV_W-1];
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[DIV_W-2:0], ge};
        rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_LEN_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

>>> sv/imutc_sqrt.sv
// ----------------------------------------------------------------------------
// imutc_sqrt
// Digit-by-digit integer square root of a 32-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module imutc_sqrt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [imutc_pkg::SQ_W-1:0]       value,
  output logic                             busy,
  output logic                             done,
  output logic [imutc_pkg::ROOT_W-1:0]     root
);
  import imutc_pkg::*;

  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (SQ_W - 2);

  logic [SQ_W-1:0] v_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic            busy_r;
  logic            done_r;
  logic [SQ_W:0]   sum;
  logic            ge;

  assign sum = {1'b0, r_r} + {1'b0, bit_r};
  assign ge  = {1'b0, v_r} >= sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= value;
        r_r    <= '0;
        bit_r  <= TOP_BIT;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          v_r <= v_r - sum[SQ_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = r_r[ROOT_W-1:0];

endmodule

>>> sv/imutc_cordic.sv
// ----------------------------------------------------------------------------
// imutc_cordic
// Vectoring CORDIC atan2, one micro-rotation per cycle, angle in centidegrees.
// ----------------------------------------------------------------------------
module imutc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic signed [imutc_pkg::CORDIC_IN_W-1:0] y_in,
  input  logic signed [imutc_pkg::CORDIC_IN_W-1:0] x_in,
  output logic                                     busy,
  output logic                                     done,
  output logic signed [imutc_pkg::ANG_W-1:0]       angle
);
  import imutc_pkg::*;

  localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(STEPS - 1);

  logic signed [CORDIC_XY_W-1:0] x_r;
  logic signed [CORDIC_XY_W-1:0] y_r;
  logic signed [CORDIC_Z_W-1:0]  z_r;
  logic [ATAN_IDX_W-1:0]         i_r;
  logic                          busy_r;
  logic                          done_r;

  logic signed [CORDIC_XY_W-1:0] xs;
  logic signed [CORDIC_XY_W-1:0] ys;
  logic signed [CORDIC_XY_W-1:0] sx;
  logic signed [CORDIC_XY_W-1:0] sy;
  logic signed [CORDIC_Z_W-1:0]  at;
  logic signed [CORDIC_Z_W-1:0]  zr;

  assign xs = CORDIC_XY_W'(x_in) <<< PRESHIFT;
  assign ys = CORDIC_XY_W'(y_in) <<< PRESHIFT;
  assign sx = x_r >>> i_r;
  assign sy = y_r >>> i_r;
  assign at = $signed({{(CORDIC_Z_W-ATAN_W){1'b0}}, atan_lut(i_r)});
  assign zr = z_r + Z_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          z_r    <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            // rotate by a half turn into the right half plane
            z_r <= (y_in >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
            x_r <= -xs;
            y_r <= -ys;
          end else begin
            z_r <= '0;
            x_r <= xs;
            y_r <= ys;
          end
        end
      end else if (busy_r) begin
        if (y_r > 0) begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign angle = ANG_W'(zr >>> 16);

endmodule
